// ----- hw/rtl/trl_pkg.sv -----
// Shared types, register map and reset values for the two-road traffic light.
package trl_pkg;

   // Default width of the phase and closed-time counters
   localparam int TIME_BITS_DEF = 8;

   // Configuration register width and address map
   localparam int CFG_W      = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = 3;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_MAIN_GREEN = 3'd0,
      REG_YELLOW     = 3'd1,
      REG_SIDE_GREEN = 3'd2,
      REG_WALK       = 3'd3,
      REG_MAX_CLOSED = 3'd4
   } reg_idx_type;

   localparam logic [CFG_W-1:0] MAIN_GREEN_RST = 8'd20;
   localparam logic [CFG_W-1:0] YELLOW_RST     = 8'd3;
   localparam logic [CFG_W-1:0] SIDE_GREEN_RST = 8'd20;
   localparam logic [CFG_W-1:0] WALK_RST       = 8'd5;
   localparam logic [CFG_W-1:0] MAX_CLOSED_RST = 8'd60;

   // Phase codes, as shown on the phase field
   typedef enum logic [2:0] {
      PH_MAIN_GREEN  = 3'd0,
      PH_MAIN_YELLOW = 3'd1,
      PH_MAIN_WALK   = 3'd2,
      PH_SIDE_GREEN  = 3'd3,
      PH_SIDE_YELLOW = 3'd4,
      PH_SIDE_WALK   = 3'd5
   } phase_type;

   // Light codes
   localparam logic [1:0] CAR_RED    = 2'd0;
   localparam logic [1:0] CAR_GREEN  = 2'd1;
   localparam logic [1:0] CAR_YELLOW = 2'd2;
   localparam logic       WALK_RED   = 1'b0;
   localparam logic       WALK_GREEN = 1'b1;

   // Walk button groups
   localparam logic [3:0] MAIN_BUTTONS = 4'b0011;
   localparam logic [3:0] SIDE_BUTTONS = 4'b1100;

   // Configuration set handed to the phase engine
   typedef struct packed {
      logic [CFG_W-1:0] main_green_ticks;
      logic [CFG_W-1:0] yellow_ticks;
      logic [CFG_W-1:0] side_green_ticks;
      logic [CFG_W-1:0] walk_ticks;
      logic [CFG_W-1:0] max_closed_ticks;
   } cfg_type;

   // One result item
   typedef struct packed {
      logic [1:0] main_car_light;
      logic       main_walk_light;
      logic [1:0] side_car_light;
      logic       side_walk_light;
      logic [2:0] phase;
   } rsp_type;

endpackage

// ----- hw/rtl/two_road_traffic_light_with_walk.sv -----
// Top level of the two-road traffic light with pedestrian walk phases.
//
// Each item on the req_ channel is one tick carrying the walk buttons pressed
// in that tick; the block answers with one item on the rsp_ channel showing
// the lights of the phase in force during that tick, then advances the phase.
// The phase engine updates its state in the cycle the item is accepted and
// the lights land in a single output register, so a new item is taken every
// cycle as long as the output register is empty or being drained in the same
// cycle. Timing registers (main green, yellow, side green, walk, max closed
// time) sit at byte addresses 0x0..0x10 of the APB-style port; the user must
// write them only while the block is idle, which the block does not enforce.
module two_road_traffic_light_with_walk #(
   parameter int TIME_BITS = trl_pkg::TIME_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // Tick input
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [3:0]                     req_buttons,
   // Light output
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_main_car_light,
   output logic                           rsp_main_walk_light,
   output logic [1:0]                     rsp_side_car_light,
   output logic                           rsp_side_walk_light,
   output logic [2:0]                     rsp_phase,
   // Configuration
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [trl_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [trl_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [trl_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import trl_pkg::*;

   cfg_type cfg;
   rsp_type core_rsp;
   rsp_type rsp_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    take;

   trl_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Accept while the output register is free or draining
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign take      = req_valid & req_ready;

   trl_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .buttons (req_buttons),
      .cfg     (cfg),
      .rsp     (core_rsp)
   );

   // Hold the result until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_main_car_light  = rsp_ff.main_car_light;
   assign rsp_main_walk_light = rsp_ff.main_walk_light;
   assign rsp_side_car_light  = rsp_ff.side_car_light;
   assign rsp_side_walk_light = rsp_ff.side_walk_light;
   assign rsp_phase           = rsp_ff.phase;

endmodule

// ----- hw/rtl/trl_regs.sv -----
// APB-style configuration register file for the traffic light timing.
module trl_regs (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [trl_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [trl_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [trl_pkg::CSR_DATA_W-1:0] prdata,
   output logic                          pready,
   output trl_pkg::cfg_type              cfg
);
   import trl_pkg::*;

   cfg_type                cfg_ff;
   cfg_type                cfg_in;
   logic [REG_IDX_W-1:0]   idx;
   logic                   wr_en;
   logic [CFG_W-1:0]       rd_val;

   assign idx    = paddr[CSR_ADDR_W-1:2];
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_MAIN_GREEN: cfg_in.main_green_ticks = pwdata[CFG_W-1:0];
            REG_YELLOW:     cfg_in.yellow_ticks     = pwdata[CFG_W-1:0];
            REG_SIDE_GREEN: cfg_in.side_green_ticks = pwdata[CFG_W-1:0];
            REG_WALK:       cfg_in.walk_ticks       = pwdata[CFG_W-1:0];
            REG_MAX_CLOSED: cfg_in.max_closed_ticks = pwdata[CFG_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.main_green_ticks <= MAIN_GREEN_RST;
         cfg_ff.yellow_ticks     <= YELLOW_RST;
         cfg_ff.side_green_ticks <= SIDE_GREEN_RST;
         cfg_ff.walk_ticks       <= WALK_RST;
         cfg_ff.max_closed_ticks <= MAX_CLOSED_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Return the addressed register
   always_comb begin
      case (idx)
         REG_MAIN_GREEN: rd_val = cfg_ff.main_green_ticks;
         REG_YELLOW:     rd_val = cfg_ff.yellow_ticks;
         REG_SIDE_GREEN: rd_val = cfg_ff.side_green_ticks;
         REG_WALK:       rd_val = cfg_ff.walk_ticks;
         REG_MAX_CLOSED: rd_val = cfg_ff.max_closed_ticks;
         default:        rd_val = '0;
      endcase
   end

   assign prdata = {{(CSR_DATA_W-CFG_W){1'b0}}, rd_val};
   assign cfg    = cfg_ff;

endmodule

// ----- hw/rtl/trl_core.sv -----
// Phase engine: walk request latch, phase and closed-time counters, light decode.
module trl_core #(
   parameter int TIME_BITS = trl_pkg::TIME_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             take,
   input  logic [3:0]       buttons,
   input  trl_pkg::cfg_type cfg,
   output trl_pkg::rsp_type rsp
);
   import trl_pkg::*;

   localparam int CMP_W = ((TIME_BITS > CFG_W) ? TIME_BITS : CFG_W) + 1;
   localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

   phase_type              phase_ff, phase_in;
   logic [TIME_BITS-1:0]   count_ff, count_in;
   logic [TIME_BITS-1:0]   closed_ff, closed_in;
   logic [3:0]             walk_ff, walk_in;

   logic [3:0]             req_all;
   logic [CFG_W-1:0]       len;
   logic [CMP_W-1:0]       count_nxt;
   logic                   len_done;
   logic [TIME_BITS-1:0]   closed_inc;
   logic                   closed_hit;
   logic                   done;

   assign req_all = walk_ff | buttons;

   // Pick the length of the current phase
   always_comb begin
      case (phase_ff)
         PH_MAIN_YELLOW, PH_SIDE_YELLOW: len = cfg.yellow_ticks;
         PH_MAIN_WALK,   PH_SIDE_WALK:   len = cfg.walk_ticks;
         PH_SIDE_GREEN:                  len = cfg.side_green_ticks;
         default:                        len = cfg.main_green_ticks;
      endcase
   end

   // Phase end and closed-time limit
   assign count_nxt  = CMP_W'(count_ff) + CMP_W'(1);
   assign len_done   = (count_nxt >= CMP_W'(len)) || (count_ff == TMAX);
   assign closed_inc = (closed_ff == TMAX) ? closed_ff : closed_ff + 1'b1;
   assign closed_hit = CMP_W'(closed_inc) >= CMP_W'(cfg.max_closed_ticks);

   // Next state
   always_comb begin
      phase_in  = phase_ff;
      closed_in = closed_ff;
      walk_in   = req_all;
      done      = len_done;
      case (phase_ff)
         PH_MAIN_GREEN: begin
            if (len_done) begin
               closed_in = '0;
               phase_in  = PH_MAIN_YELLOW;
            end
         end
         PH_MAIN_YELLOW: begin
            if (len_done) begin
               if ((req_all & MAIN_BUTTONS) != 4'b0) begin
                  walk_in  = req_all & SIDE_BUTTONS;
                  phase_in = PH_MAIN_WALK;
               end else begin
                  phase_in = PH_SIDE_GREEN;
               end
            end
         end
         PH_MAIN_WALK: begin
            if (len_done) phase_in = PH_SIDE_GREEN;
         end
         PH_SIDE_GREEN: begin
            closed_in = closed_inc;
            done      = len_done | closed_hit;
            if (done) phase_in = PH_SIDE_YELLOW;
         end
         PH_SIDE_YELLOW: begin
            if (len_done) begin
               if ((req_all & SIDE_BUTTONS) != 4'b0) begin
                  walk_in  = req_all & MAIN_BUTTONS;
                  phase_in = PH_SIDE_WALK;
               end else begin
                  phase_in = PH_MAIN_GREEN;
               end
            end
         end
         PH_SIDE_WALK: begin
            if (len_done) phase_in = PH_MAIN_GREEN;
         end
         default: begin
            // Unused codes behave as main green
            phase_in = PH_MAIN_GREEN;
            if (len_done) begin
               closed_in = '0;
               phase_in  = PH_MAIN_YELLOW;
            end
         end
      endcase
      count_in = done ? '0 : count_ff + 1'b1;
   end

   // Advance on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_MAIN_GREEN;
         count_ff  <= '0;
         closed_ff <= '0;
         walk_ff   <= '0;
      end else if (take) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         closed_ff <= closed_in;
         walk_ff   <= walk_in;
      end
   end

   // Decode the lights of the current phase
   always_comb begin
      rsp.main_car_light  = CAR_RED;
      rsp.main_walk_light = WALK_RED;
      rsp.side_car_light  = CAR_RED;
      rsp.side_walk_light = WALK_RED;
      rsp.phase           = phase_ff;
      case (phase_ff)
         PH_MAIN_GREEN:  rsp.main_car_light = CAR_GREEN;
         PH_MAIN_YELLOW: rsp.main_car_light = CAR_YELLOW;
         PH_MAIN_WALK: begin
            rsp.main_walk_light = WALK_GREEN;
            rsp.side_car_light  = CAR_GREEN;
         end
         PH_SIDE_GREEN:  rsp.side_car_light  = CAR_GREEN;
         PH_SIDE_YELLOW: rsp.side_car_light  = CAR_YELLOW;
         PH_SIDE_WALK:   rsp.side_walk_light = WALK_GREEN;
         default: begin
            rsp.main_car_light = CAR_GREEN;
            rsp.phase          = PH_MAIN_GREEN;
         end
      endcase
   end

endmodule
